// ===== hw/rtl/mbrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrtu_pkg
// shared types and constants of the modbus rtu slave frame engine
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_LOCAL = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [0:0] CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic [0:0] CFG_SILENCE_TICKS = 1'b1;

    localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;
    localparam logic [7:0]  FUNC_READ      = 8'd3;
    localparam logic [7:0]  FUNC_WRITE     = 8'd6;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] SAVE_LOW       = 16'd49;
    localparam logic [15:0] SAVE_HIGH      = 16'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CRC_RX,
        ST_CHECK,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_BYTE_CRC,
        ST_EMIT,
        ST_WR_STORE,
        ST_ECHO
    } state_t;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       load;
    } crc_ctrl_t;

endpackage

// ===== hw/rtl/mbrtu_ram.sv =====
// ----------------------------------------------------------------------------
// mbrtu_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module mbrtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mbrtu_crc.sv =====
// ----------------------------------------------------------------------------
// mbrtu_crc
// bit-serial crc-16 unit, one data bit per cycle
// ----------------------------------------------------------------------------
module mbrtu_crc (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbrtu_pkg::crc_ctrl_t ctrl,
    output logic                 busy,
    output logic [15:0]          crc
);
    import mbrtu_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sh_reg, sh_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        fb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            crc_reg <= CRC_INIT;
            sh_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
            sh_reg  <= sh_next;
        end
    end

    always_comb
    begin
        crc_next = crc_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        fb       = crc_reg[0] ^ sh_reg[0];
        if (ctrl.start)
        begin
            crc_next = CRC_INIT;
        end
        if (ctrl.load)
        begin
            sh_next  = ctrl.data;
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = fb ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            sh_next  = sh_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
        end
    end

    assign busy = (cnt_reg != 4'd0);
    assign crc  = crc_reg;

endmodule

// ===== hw/rtl/modbus_rtu_slave_frame_engine.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine
// modbus rtu slave for functions 3 and 6 with bit-serial crc
//
// channel | signals                                   | direction
// in      | in_valid in_ready kind rx_byte reg_index reg_value | to block
// out     | out_valid out_ready tx_byte last_byte save_request | from block
// cfg     | cfg_valid cfg_ready cfg_index cfg_data   | to block
//
// a byte that closes a frame starts a crc check over its first six bytes;
// each read response byte then goes through the bit-serial crc, with data
// words read from ram, and a write is echoed from the frame buffer
// after reset a clearing pass zeroes the register ram while in_ready is low;
// cfg writes are taken at any time
// a stalled output holds the engine in place
// ----------------------------------------------------------------------------
module modbus_rtu_slave_frame_engine #(
    parameter int REG_DEPTH = 256,
    parameter int MAX_READ  = 29
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  reg_index,
    input  logic signed [15:0] reg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        last_byte,
    output logic        save_request,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import mbrtu_pkg::*;

    localparam int AW = $clog2(REG_DEPTH);

    state_t state_reg, state_next;
    logic [7:0]  slave_reg, ticks_reg;
    logic [7:0]  fb_reg [8];
    logic [7:0]  fb_wdata;
    logic        fb_we;
    logic [2:0]  fb_waddr;
    logic [3:0]  cnt_reg, cnt_next;
    logic        recv_reg, recv_next;
    logic [7:0]  timer_reg, timer_next;
    logic [AW:0] clr_reg, clr_next;
    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  len_reg, len_next;
    logic [8:0]  ra_reg, ra_next;
    logic [15:0] word_reg, word_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next, os_reg, os_next;
    logic        ov_reg, ov_next;
    logic        low_reg, low_next;
    crc_ctrl_t   cc;
    logic        crc_busy;
    logic [15:0] crc;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0] ram_wdata, ram_rdata;
    logic [15:0] f_start, f_word;
    logic [16:0] rd_end;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !ov_reg || out_ready;
    assign f_start   = {fb_reg[2], fb_reg[3]};
    assign f_word    = {fb_reg[4], fb_reg[5]};
    assign rd_end    = {1'b0, f_start} + {1'b0, f_word};

    mbrtu_crc u_crc (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (cc),
        .busy (crc_busy),
        .crc  (crc)
    );

    mbrtu_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= 8'd1;
            ticks_reg <= 8'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS: slave_reg <= cfg_data;
                CFG_SILENCE_TICKS: ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            fb_reg[fb_waddr] <= fb_wdata;
        end
        word_reg <= word_next;
        ob_reg   <= ob_next;
        ol_reg   <= ol_next;
        os_reg   <= os_next;
        ra_reg   <= ra_next;
        len_reg  <= len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            recv_reg  <= 1'b0;
            timer_reg <= '0;
            clr_reg   <= '0;
            pos_reg   <= '0;
            ov_reg    <= 1'b0;
            low_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            recv_reg  <= recv_next;
            timer_reg <= timer_next;
            clr_reg   <= clr_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
            low_reg   <= low_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        recv_next  = recv_reg;
        timer_next = timer_reg;
        clr_next   = clr_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        ra_next    = ra_reg;
        word_next  = word_reg;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        os_next    = os_reg;
        ov_next    = ov_reg && !out_ready;
        low_next   = low_reg;
        fb_we      = 1'b0;
        fb_waddr   = cnt_reg[2:0];
        fb_wdata   = rx_byte;
        cc         = '0;
        ram_we     = 1'b0;
        ram_addr   = ra_reg[AW-1:0];
        ram_wdata  = f_word;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[AW-1:0];
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(REG_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (kind_t'(kind))
                        KIND_BYTE:
                        begin
                            if (recv_reg || rx_byte == slave_reg
                                || rx_byte == BROADCAST_ADDR)
                            begin
                                fb_we      = 1'b1;
                                fb_waddr   = recv_reg ? cnt_reg[2:0] : 3'd0;
                                timer_next = '0;
                                if (recv_reg && cnt_reg == 4'd7)
                                begin
                                    cnt_next   = '0;
                                    recv_next  = 1'b0;
                                    pos_next   = '0;
                                    cc.start   = 1'b1;
                                    state_next = ST_CRC_RX;
                                end
                                else
                                begin
                                    recv_next = 1'b1;
                                    cnt_next  = recv_reg ? cnt_reg + 4'd1 : 4'd1;
                                end
                            end
                        end
                        KIND_TICK:
                        begin
                            if (recv_reg)
                            begin
                                timer_next = timer_reg + 8'd1;
                                if (timer_reg + 8'd1 == ticks_reg)
                                begin
                                    timer_next = '0;
                                    cnt_next   = '0;
                                    recv_next  = 1'b0;
                                end
                            end
                        end
                        KIND_LOCAL:
                        begin
                            if ({1'b0, reg_index} < 9'(REG_DEPTH))
                            begin
                                ram_we    = 1'b1;
                                ram_addr  = reg_index[AW-1:0];
                                ram_wdata = reg_value;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CRC_RX:
            begin
                if (!crc_busy && !cc.start)
                begin
                    if (pos_reg == 7'd6)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cc.load  = 1'b1;
                        cc.data  = fb_reg[pos_reg[2:0]];
                        pos_next = pos_reg + 7'd1;
                    end
                end
            end
            ST_CHECK:
            begin
                state_next = ST_IDLE;
                if (fb_reg[6] == crc[7:0] && fb_reg[7] == crc[15:8]
                    && (fb_reg[0] == slave_reg || fb_reg[0] == BROADCAST_ADDR))
                begin
                    if (fb_reg[1] == FUNC_READ)
                    begin
                        if (f_word <= 16'(MAX_READ) && rd_end <= 17'(REG_DEPTH))
                        begin
                            len_next   = 7'(3 + 2 * fb_reg[5][4:0]);
                            ra_next    = {1'b0, fb_reg[3]};
                            pos_next   = '0;
                            cc.start   = 1'b1;
                            state_next = ST_BYTE_CRC;
                        end
                    end
                    else if (fb_reg[1] == FUNC_WRITE)
                    begin
                        if (f_start < 16'(REG_DEPTH))
                        begin
                            state_next = ST_WR_STORE;
                        end
                    end
                end
            end
            ST_WR_STORE:
            begin
                ram_we     = 1'b1;
                ram_addr   = fb_reg[3][AW-1:0];
                ram_wdata  = f_word;
                pos_next   = '0;
                state_next = ST_ECHO;
            end
            ST_ECHO:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    ob_next  = fb_reg[pos_reg[2:0]];
                    ol_next  = (pos_reg == 7'd7);
                    os_next  = (f_start > SAVE_LOW) && (f_start < SAVE_HIGH);
                    pos_next = pos_reg + 7'd1;
                    if (pos_reg == 7'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BYTE_CRC:
            begin
                if (!crc_busy && !cc.start && out_free)
                begin
                    if (pos_reg == len_reg)
                    begin
                        ob_next    = crc[7:0];
                        word_next  = {8'd0, crc[15:8]};
                        ov_next    = 1'b1;
                        ol_next    = 1'b0;
                        os_next    = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else if (pos_reg >= 7'd3 && pos_reg[0])
                    begin
                        state_next = ST_RD_ADDR;
                    end
                    else
                    begin
                        if (pos_reg == 7'd0)
                        begin
                            ob_next = fb_reg[0];
                        end
                        else if (pos_reg == 7'd1)
                        begin
                            ob_next = fb_reg[1];
                        end
                        else if (pos_reg == 7'd2)
                        begin
                            ob_next = {fb_reg[5][6:0], 1'b0};
                        end
                        else
                        begin
                            ob_next = word_reg[7:0];
                        end
                        cc.load  = 1'b1;
                        cc.data  = ob_next;
                        ov_next  = 1'b1;
                        ol_next  = 1'b0;
                        os_next  = 1'b0;
                        pos_next = pos_reg + 7'd1;
                    end
                end
            end
            ST_RD_ADDR:
            begin
                ram_addr   = ra_reg[AW-1:0];
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                if (out_free)
                begin
                    word_next  = ram_rdata;
                    ob_next    = ram_rdata[15:8];
                    cc.load    = 1'b1;
                    cc.data    = ram_rdata[15:8];
                    ov_next    = 1'b1;
                    ol_next    = 1'b0;
                    os_next    = 1'b0;
                    pos_next   = pos_reg + 7'd1;
                    ra_next    = ra_reg + 9'd1;
                    state_next = ST_BYTE_CRC;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ob_next    = word_reg[7:0];
                    ov_next    = 1'b1;
                    ol_next    = 1'b1;
                    os_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        low_next = ol_next;
    end

    assign out_valid    = ov_reg;
    assign tx_byte      = ob_reg;
    assign last_byte    = ol_reg && low_reg;
    assign save_request = os_reg;

endmodule
